### design/vector_dedup_count_table_macros.svh
// Assertion macros shared by the vector dedup count table modules.
// No dependencies.
`ifndef VECTOR_DEDUP_COUNT_TABLE_MACROS_SVH
`define VECTOR_DEDUP_COUNT_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VDCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define VDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/vdct_pkg.sv
// Package for the vector dedup count table: sizes, types and controller commands.
// No dependencies.
package vdct_pkg;
	localparam int TableDepth = 4096;
	localparam int VectorLen = 8;
	localparam int IdxW = $clog2(TableDepth);
	localparam int UsedW = IdxW + 1;
	localparam int ElemW = 16;
	localparam int HitsW = 24;
	localparam int ThrW = 34;
	localparam int SqW = 34;
	localparam int SumW = 35;
	localparam logic [HitsW-1:0] HitsMax = '1;
	localparam logic [ThrW-1:0] ThrReset = 34'd107374;

	typedef logic [ElemW-1:0] elem_t;
	typedef elem_t [VectorLen-1:0] vec_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_CMP, ST_UPD, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture input item
		logic clear;      // reset used count
		logic start;      // reset scan index
		logic rd;         // issue read of entry at scan index
		logic hit_upd;    // write back incremented count
		logic append;     // write new entry
		logic set_full;   // mark drop result
		logic out_load;   // present result
	} cmd_t;

	typedef struct packed {
		logic is_vec;
		logic scan_done;  // every used entry has been read
		logic cmp_busy;   // a compare is in flight
		logic match;      // registered compare result of an earlier entry
		logic room;       // used count below depth
		logic out_busy;   // result register still full
	} stat_t;
endpackage

### design/vdct_ctrl.sv
// Controller state machine for the vector dedup count table.
// Depends on vdct_pkg and vector_dedup_count_table_macros.svh.
module vdct_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  vdct_pkg::stat_t stat,
	output vdct_pkg::cmd_t cmd
);
	`include "vector_dedup_count_table_macros.svh"
	vdct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= vdct_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdct_pkg::ST_IDLE: begin
				if (in_valid) state_d = vdct_pkg::ST_READ;
			end
			vdct_pkg::ST_READ: begin
				if (!stat.is_vec || stat.scan_done) state_d = vdct_pkg::ST_UPD;
				else state_d = vdct_pkg::ST_CMP;
			end
			vdct_pkg::ST_CMP: begin
				if (stat.match) state_d = vdct_pkg::ST_UPD;
				else if (stat.scan_done && !stat.cmp_busy) state_d = vdct_pkg::ST_UPD;
			end
			vdct_pkg::ST_UPD: state_d = vdct_pkg::ST_OUT;
			vdct_pkg::ST_OUT: begin
				if (!stat.out_busy) state_d = vdct_pkg::ST_IDLE;
			end
			default: state_d = vdct_pkg::ST_IDLE;
		endcase
	end

	// In CMP the compare pipeline has one entry in flight: the read issued last
	// cycle is being compared while the next read goes out.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vdct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.start = in_valid;
			end
			vdct_pkg::ST_READ: begin
				cmd.rd = stat.is_vec && !stat.scan_done;
			end
			vdct_pkg::ST_CMP: begin
				cmd.rd = !stat.match && !stat.scan_done;
			end
			vdct_pkg::ST_UPD: begin
				cmd.clear = !stat.is_vec;
				cmd.hit_upd = stat.is_vec && stat.match;
				cmd.append = stat.is_vec && !stat.match && stat.room;
				cmd.set_full = stat.is_vec && !stat.match && !stat.room;
			end
			vdct_pkg::ST_OUT: cmd.out_load = !stat.out_busy;
			default: ;
		endcase
	end

	`VDCT_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == vdct_pkg::ST_IDLE, "ready outside idle")
	`VDCT_ASSERT_NEXT(a_load_read, clk, arst_n, cmd.load, state_q == vdct_pkg::ST_READ, "load not followed by read")
	`VDCT_ASSERT_IMP(a_one_upd, clk, arst_n, cmd.hit_upd, !cmd.append && !cmd.set_full, "update conflict")
endmodule

### design/vdct_dp.sv
// Datapath: entry memories, scan counter, squared-distance compare and result register.
// Depends on vdct_pkg and vector_dedup_count_table_macros.svh.
module vdct_dp (
	input  logic clk,
	input  logic arst_n,
	input  vdct_pkg::cmd_t cmd,
	output vdct_pkg::stat_t stat,
	input  logic cfg_we,
	input  logic [vdct_pkg::ThrW-1:0] cfg_data,
	input  logic cmd_in,
	input  vdct_pkg::vec_t vec_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [11:0] entry_index,
	output logic is_new,
	output logic table_full,
	output logic [vdct_pkg::HitsW-1:0] entry_hits,
	output logic [12:0] entries_used
);
	`include "vector_dedup_count_table_macros.svh"
	localparam int IW = vdct_pkg::IdxW;
	localparam int UW = vdct_pkg::UsedW;

	vdct_pkg::vec_t vec_mem [vdct_pkg::TableDepth];
	logic [vdct_pkg::HitsW-1:0] hit_mem [vdct_pkg::TableDepth];

	logic [vdct_pkg::ThrW-1:0] thr_q;
	logic [UW-1:0] used_q, scan_q;
	logic is_vec_q, match_q, cmp_vld_q;
	vdct_pkg::vec_t vin_q, rd_vec_s1;
	logic [vdct_pkg::HitsW-1:0] rd_hits_s1, match_hits_q;
	logic [IW-1:0] match_idx_q, cmp_idx_q;
	logic [IW-1:0] r_idx_q;
	logic r_new_q, r_full_q;
	logic [vdct_pkg::HitsW-1:0] r_hits_q;
	logic out_valid_q;
	logic [vdct_pkg::SumW-1:0] dist_sum;
	logic cmp_hit;
	logic first_hit;
	logic [vdct_pkg::HitsW-1:0] hits_inc;
	logic [IW-1:0] hit_waddr;
	logic [vdct_pkg::HitsW-1:0] hit_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= vdct_pkg::ThrReset;
		else if (cfg_we) thr_q <= cfg_data;
	end

	always_comb begin
		logic [vdct_pkg::ElemW:0] d;
		logic [vdct_pkg::SqW-1:0] sq;
		dist_sum = '0;
		for (int j = 0; j < vdct_pkg::VectorLen; j++) begin
			d = (rd_vec_s1[j] > vin_q[j]) ?
				{1'b0, rd_vec_s1[j]} - {1'b0, vin_q[j]} :
				{1'b0, vin_q[j]} - {1'b0, rd_vec_s1[j]};
			sq = vdct_pkg::SqW'(d) * vdct_pkg::SqW'(d);
			dist_sum = dist_sum + vdct_pkg::SumW'(sq);
		end
	end

	assign cmp_hit = cmp_vld_q && (dist_sum <= {1'b0, thr_q});
	// Only the first hit of a scan counts; a later entry read speculatively is ignored.
	assign first_hit = cmp_hit && !match_q;

	assign hits_inc = (match_hits_q == vdct_pkg::HitsMax) ? match_hits_q :
		match_hits_q + 1'b1;
	assign hit_waddr = cmd.append ? used_q[IW-1:0] : match_idx_q;
	assign hit_wdata = cmd.append ? vdct_pkg::HitsW'(1) : hits_inc;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_vec_s1 <= vec_mem[scan_q[IW-1:0]];
			rd_hits_s1 <= hit_mem[scan_q[IW-1:0]];
		end
		if (cmd.append) vec_mem[used_q[IW-1:0]] <= vin_q;
		if (cmd.append || cmd.hit_upd) hit_mem[hit_waddr] <= hit_wdata;
		if (cmd.load) vin_q <= vec_in;
		if (cmd.rd) cmp_idx_q <= scan_q[IW-1:0];
		if (first_hit) begin
			match_idx_q <= cmp_idx_q;
			match_hits_q <= rd_hits_s1;
		end
		if (cmd.hit_upd) begin
			r_idx_q <= match_idx_q;
			r_hits_q <= hits_inc;
			r_new_q <= 1'b0;
			r_full_q <= 1'b0;
		end else if (cmd.append) begin
			r_idx_q <= used_q[IW-1:0];
			r_hits_q <= vdct_pkg::HitsW'(1);
			r_new_q <= 1'b1;
			r_full_q <= 1'b0;
		end else if (cmd.set_full || cmd.clear) begin
			r_idx_q <= '0;
			r_hits_q <= '0;
			r_new_q <= 1'b0;
			r_full_q <= cmd.set_full;
		end
		if (cmd.out_load) begin
			entry_index <= 12'(r_idx_q);
			is_new <= r_new_q;
			table_full <= r_full_q;
			entry_hits <= r_hits_q;
			entries_used <= 13'(used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			scan_q <= '0;
			is_vec_q <= 1'b0;
			match_q <= 1'b0;
			cmp_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				is_vec_q <= cmd_in;
				match_q <= 1'b0;
			end else if (cmp_hit) begin
				match_q <= 1'b1;
			end
			cmp_vld_q <= cmd.rd;
			if (cmd.start) scan_q <= '0;
			else if (cmd.rd) scan_q <= scan_q + 1'b1;
			if (cmd.clear) used_q <= '0;
			else if (cmd.append) used_q <= used_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Match is known in CMP only via the registered hit of the previous compare;
	// with no match, CMP ends once the scan is done and no compare is in flight.
	assign stat.is_vec = is_vec_q;
	assign stat.match = match_q;
	assign stat.scan_done = (scan_q == used_q);
	assign stat.cmp_busy = cmp_vld_q;
	assign stat.room = used_q < UW'(vdct_pkg::TableDepth);
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;

	`VDCT_ASSERT_IMP(a_used_range, clk, arst_n, 1'b1, used_q <= UW'(vdct_pkg::TableDepth), "used count overflow")
	`VDCT_ASSERT_IMP(a_app_room, clk, arst_n, cmd.append, stat.room, "append into full table")
	`VDCT_ASSERT_IMP(a_scan_bound, clk, arst_n, cmd.rd, scan_q < used_q, "read past used entries")
endmodule

### design/vector_dedup_count_table.sv
// Top level of the vector dedup count table.
// Depends on vdct_pkg, vdct_ctrl and vdct_dp.
// Leader-clustering table: each transfer either clears the table (cmd 0) or
// presents an eight-element Q1.15 vector (cmd 1). Stored entries are read from
// an on-chip memory one per cycle in insertion order and compared against the
// vector with eight parallel squarers; the first entry whose sum of squared
// differences is at or below the threshold register has its saturating hit count
// incremented. Without a match the vector is appended if there is room, else
// table_full is reported. One result transfer follows every input transfer.
// An item's scan reads the stored entries in order until the match (all of
// them without one) through the single memory read port. A new item is
// taken only after the previous result has moved into the output register.
// There is no clearing pass after reset: entries above the used count are
// never read.
module vector_dedup_count_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [33:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic [15:0] hidden_0,
	input  logic [15:0] hidden_1,
	input  logic [15:0] hidden_2,
	input  logic [15:0] hidden_3,
	input  logic [15:0] hidden_4,
	input  logic [15:0] hidden_5,
	input  logic [15:0] hidden_6,
	input  logic [15:0] hidden_7,
	output logic out_valid,
	input  logic out_ready,
	output logic [11:0] entry_index,
	output logic is_new,
	output logic table_full,
	output logic [23:0] entry_hits,
	output logic [12:0] entries_used
);
	vdct_pkg::cmd_t ctl;
	vdct_pkg::stat_t st;
	vdct_pkg::vec_t vec;

	assign vec = {hidden_7, hidden_6, hidden_5, hidden_4,
		hidden_3, hidden_2, hidden_1, hidden_0};

	vdct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(st), .cmd(ctl)
	);

	vdct_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(ctl), .stat(st),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .cmd_in(cmd), .vec_in(vec),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_index(entry_index), .is_new(is_new), .table_full(table_full),
		.entry_hits(entry_hits), .entries_used(entries_used)
	);
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_dedup_count_table.
// Depends on vdct_pkg and the vector_dedup_count_table RTL; predicts every result itself.
module tb;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vdct_pkg::ThrW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic [15:0] hidden_0, hidden_1, hidden_2, hidden_3;
	logic [15:0] hidden_4, hidden_5, hidden_6, hidden_7;
	logic out_valid;
	logic out_ready;
	logic [11:0] entry_index;
	logic is_new;
	logic table_full;
	logic [23:0] entry_hits;
	logic [12:0] entries_used;

	// Command codes of the cmd field.
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_VECTOR = 1'b1;

	typedef struct packed {
		logic [11:0] index;
		logic fresh;
		logic full;
		logic [23:0] hits;
		logic [12:0] used;
	} lookup_t;

	vector_dedup_count_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.hidden_0(hidden_0), .hidden_1(hidden_1), .hidden_2(hidden_2),
		.hidden_3(hidden_3), .hidden_4(hidden_4), .hidden_5(hidden_5),
		.hidden_6(hidden_6), .hidden_7(hidden_7),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_index(entry_index), .is_new(is_new), .table_full(table_full),
		.entry_hits(entry_hits), .entries_used(entries_used)
	);

	// Shadow copy of the table that the predictor keeps.
	vdct_pkg::vec_t table_vecs [vdct_pkg::TableDepth];
	logic [vdct_pkg::HitsW-1:0] table_hits [vdct_pkg::TableDepth];
	int unsigned table_used;
	logic [vdct_pkg::ThrW-1:0] threshold;

	lookup_t lookups_due[$];
	int errors;
	int unsigned cycles;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang in the block ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Predicts one lookup or clear, updating the shadow table as the block should.
	function automatic lookup_t predict_lookup(input logic c, input vdct_pkg::vec_t v);
		lookup_t r;
		logic [vdct_pkg::SumW-1:0] dsum;
		logic [16:0] d;
		int unsigned i;
		r = '0;
		if (c == CMD_CLEAR) begin
			table_used = 0;
			return r;
		end
		for (i = 0; i < table_used; i++) begin
			dsum = '0;
			for (int j = 0; j < vdct_pkg::VectorLen; j++) begin
				d = (table_vecs[i][j] > v[j]) ? table_vecs[i][j] - v[j] :
					v[j] - table_vecs[i][j];
				dsum += vdct_pkg::SumW'(d) * vdct_pkg::SumW'(d);
			end
			if (dsum <= vdct_pkg::SumW'(threshold))
				break;
		end
		if (i < table_used) begin
			if (table_hits[i] != vdct_pkg::HitsMax)
				table_hits[i]++;
			r.index = i[11:0];
			r.hits = table_hits[i];
		end else if (table_used < vdct_pkg::TableDepth) begin
			table_vecs[table_used] = v;
			table_hits[table_used] = vdct_pkg::HitsW'(1);
			r.index = table_used[11:0];
			r.hits = 24'd1;
			r.fresh = 1'b1;
			table_used++;
		end else begin
			r.full = 1'b1;
		end
		r.used = table_used[12:0];
		return r;
	endfunction

	// Sends one transfer and records its expected result; valid stays high until
	// the next item replaces it or an idle cycle drops it.
	task automatic send_item(input logic c, input vdct_pkg::vec_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		hidden_0 <= v[0]; hidden_1 <= v[1]; hidden_2 <= v[2]; hidden_3 <= v[3];
		hidden_4 <= v[4]; hidden_5 <= v[5]; hidden_6 <= v[6]; hidden_7 <= v[7];
		do @(posedge clk); while (!in_ready);
		lookups_due.push_back(predict_lookup(c, v));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Registers are written only once the block is idle.
	task automatic set_threshold(input logic [vdct_pkg::ThrW-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
	endtask

	function automatic vdct_pkg::vec_t random_vec();
		vdct_pkg::vec_t v;
		for (int j = 0; j < vdct_pkg::VectorLen; j++)
			case ($urandom_range(5))
				0: v[j] = 16'd0;
				1: v[j] = 16'd32768;
				2: v[j] = 16'hFFFF;
				default: v[j] = 16'($urandom_range(32768));
			endcase
		return v;
	endfunction

	// Nearby copy of a vector so that matches within a threshold happen.
	function automatic vdct_pkg::vec_t nudge_vec(input vdct_pkg::vec_t v, input int span);
		vdct_pkg::vec_t n;
		for (int j = 0; j < vdct_pkg::VectorLen; j++)
			n[j] = v[j] + 16'($urandom_range(2 * span) - span);
		return n;
	endfunction

	// Receiver: stalls at random and compares every result with the oldest prediction.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = lookups_due.pop_front();
					if (entry_index !== want.index) report("entry_index", entry_index, want.index);
					if (is_new !== want.fresh) report("is_new", is_new, want.fresh);
					if (table_full !== want.full) report("table_full", table_full, want.full);
					if (entry_hits !== want.hits) report("entry_hits", entry_hits, want.hits);
					if (entries_used !== want.used) report("entries_used", entries_used, want.used);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Extremes of the elements, clear, exact and near matches, threshold edges.
	task automatic test_directed();
		vdct_pkg::vec_t zero_v, top_v, ones_v;
		zero_v = '0;
		top_v = {vdct_pkg::VectorLen{16'd32768}};
		ones_v = {vdct_pkg::VectorLen{16'hFFFF}};
		send_item(CMD_VECTOR, zero_v);
		send_item(CMD_VECTOR, zero_v);
		send_item(CMD_VECTOR, top_v);
		send_item(CMD_VECTOR, ones_v);
		send_item(CMD_VECTOR, {vdct_pkg::VectorLen{16'h5555}});
		send_item(CMD_VECTOR, {vdct_pkg::VectorLen{16'hAAAA}});
		send_item(CMD_VECTOR, nudge_vec(top_v, 40));
		send_item(CMD_CLEAR, ones_v);
		send_item(CMD_VECTOR, top_v);
		// Threshold zero: only identical vectors match.
		set_threshold('0);
		send_item(CMD_VECTOR, top_v);
		send_item(CMD_VECTOR, {top_v[vdct_pkg::VectorLen-1:1], 16'd32767});
		// Distance of exactly one squared step sits on the threshold.
		set_threshold(34'd1);
		send_item(CMD_VECTOR, {top_v[vdct_pkg::VectorLen-1:1], 16'd32769});
		// Largest threshold: everything collapses onto the first entry.
		set_threshold({vdct_pkg::ThrW{1'b1}});
		send_item(CMD_VECTOR, ones_v);
		send_item(CMD_VECTOR, zero_v);
	endtask

	// Mostly near copies of recent vectors with random clears and new ones mixed in.
	task automatic test_random(input int count);
		vdct_pkg::vec_t recent[$];
		vdct_pkg::vec_t v;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(29) == 0) begin
				send_item(CMD_CLEAR, random_vec());
				recent.delete();
				continue;
			end
			if (recent.size() != 0 && $urandom_range(2) != 0)
				v = nudge_vec(recent[$urandom_range(recent.size() - 1)], $urandom_range(300));
			else
				v = random_vec();
			recent.push_back(v);
			send_item(CMD_VECTOR, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_CLEAR;
		{hidden_0, hidden_1, hidden_2, hidden_3} = '0;
		{hidden_4, hidden_5, hidden_6, hidden_7} = '0;
		out_ready = 1'b0;
		errors = 0;
		cycles = 0;
		threshold = vdct_pkg::ThrReset;
		table_used = 0;
		send_idle_pct = 16;
		recv_idle_pct = 48;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_threshold(vdct_pkg::ThrReset);
		test_random(45);
		send_idle_pct = 48;
		recv_idle_pct = 16;
		set_threshold(34'd4000000);
		test_random(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_threshold(34'd250000);
		test_random(35);
		wait_drained();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/vdct_pkg.sv
design/vdct_ctrl.sv
design/vdct_dp.sv
design/vector_dedup_count_table.sv
verif/tb.sv
